### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression never true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### src/stcpq_pkg.sv
// ----------------------------------------------------------------------------
// stcpq_pkg
// Sizes, codes and types of the three-class priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package stcpq_pkg;

    localparam int SLOTS_PER_CLASS = 16;
    localparam int CLASS_COUNT     = 3;
    localparam int TAG_BITS        = 32;

    localparam int CLS_W   = $clog2(CLASS_COUNT);
    localparam int HEAD_W  = $clog2(SLOTS_PER_CLASS);
    localparam int CNT_W   = $clog2(SLOTS_PER_CLASS + 1);
    localparam int SUM_W   = HEAD_W + 1;
    localparam int DEPTH   = CLASS_COUNT * SLOTS_PER_CLASS;
    localparam int ADDR_W  = $clog2(DEPTH);

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_SEND = 1'b1;

    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_SENT   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

endpackage

`default_nettype wire

### src/stable_three_class_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_three_class_priority_queue
// Three-class stable priority queue over one tag memory.
// ----------------------------------------------------------------------------
// Each class is a circular FIFO of SLOTS_PER_CLASS tags inside a single
// synchronous tag memory; heads and fill counts are held in flops. A push
// beat writes the tag and returns its status beat on the next cycle. A send
// beat registers its tag memory read, then S_READ registers its status beat.
// One beat is in flight at a time; a new input beat is taken once the
// previous one is done and the result register is free or being drained.
// Pushes to a full class are dropped with status 3, sends on an empty queue
// return status 2. No clearing pass after reset.
`default_nettype none
`include "assert_macros.svh"

module stable_three_class_priority_queue import stcpq_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_action,
    input  wire logic [1:0]  i_priority_class,
    input  wire logic [31:0] i_package_tag,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [31:0]      o_sent_tag,
    output logic [1:0]       o_sent_class
);

    logic [TAG_BITS-1:0] r_mem [DEPTH];
    logic [TAG_BITS-1:0] r_rd_data;

    logic [HEAD_W-1:0] r_head  [CLASS_COUNT];
    logic [CNT_W-1:0]  r_count [CLASS_COUNT];

    t_state            r_state;
    logic [CLS_W-1:0]  r_pend_cls;

    logic              r_out_valid;
    t_status           r_status;
    logic [31:0]       r_sent_tag;
    logic [1:0]        r_sent_class;

    logic              w_accept;
    logic              w_found;
    logic [CLS_W-1:0]  w_found_cls;
    logic [CLS_W-1:0]  w_push_cls;
    logic [CLS_W-1:0]  w_cls;
    logic [HEAD_W-1:0] w_head;
    logic [CNT_W-1:0]  w_cnt;
    logic              w_full;
    logic [SUM_W-1:0]  w_sum;
    logic [HEAD_W-1:0] w_tail;
    logic [HEAD_W-1:0] w_head_nx;
    logic [HEAD_W-1:0] w_slot;
    logic [ADDR_W-1:0] w_addr;
    logic              w_wr_en;
    logic              w_rd_en;
    logic [63:0]       w_tag64;
    logic [63:0]       w_rd64;
    logic              w_cnt_ovf;

    assign o_ready  = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        w_found     = 1'b0;
        w_found_cls = '0;
        for (int k = CLASS_COUNT - 1; k >= 0; k--) begin
            if (r_count[k] != '0) begin
                w_found     = 1'b1;
                w_found_cls = CLS_W'(k);
            end
        end
    end

    always_comb begin
        w_cnt_ovf = 1'b0;
        for (int k = 0; k < CLASS_COUNT; k++) begin
            if (32'(r_count[k]) > SLOTS_PER_CLASS) begin
                w_cnt_ovf = 1'b1;
            end
        end
    end

    assign w_push_cls = (32'(i_priority_class) >= CLASS_COUNT) ?
                        CLS_W'(CLASS_COUNT - 1) : CLS_W'(i_priority_class);
    assign w_cls      = (i_action == ACT_SEND) ? w_found_cls : w_push_cls;
    assign w_head     = r_head[w_cls];
    assign w_cnt      = r_count[w_cls];
    assign w_full     = (32'(w_cnt) >= SLOTS_PER_CLASS);

    assign w_sum      = SUM_W'(w_head) + SUM_W'(w_cnt);
    assign w_tail     = (32'(w_sum) >= SLOTS_PER_CLASS) ?
                        HEAD_W'(w_sum - SUM_W'(SLOTS_PER_CLASS)) : HEAD_W'(w_sum);
    assign w_head_nx  = (32'(w_head) == SLOTS_PER_CLASS - 1) ? '0 : w_head + 1'b1;

    assign w_slot     = (i_action == ACT_SEND) ? w_head : w_tail;
    assign w_addr     = ADDR_W'(w_cls) * ADDR_W'(SLOTS_PER_CLASS) + ADDR_W'(w_slot);

    assign w_wr_en    = w_accept && (i_action == ACT_PUSH) && !w_full;
    assign w_rd_en    = w_accept && (i_action == ACT_SEND) && w_found;

    assign w_tag64    = 64'(i_package_tag);
    assign w_rd64     = 64'(r_rd_data);

    // tag memory, one port, registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_addr] <= w_tag64[TAG_BITS-1:0];
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pend_cls  <= '0;
            for (int k = 0; k < CLASS_COUNT; k++) begin
                r_head[k]  <= '0;
                r_count[k] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && ((i_action == ACT_PUSH) || !w_found)) begin
                        r_out_valid <= 1'b1;
                    end else if (i_ready) begin
                        r_out_valid <= 1'b0;
                    end
                    if (w_accept) begin
                        if (i_action == ACT_PUSH) begin
                            if (!w_full) begin
                                r_count[w_cls] <= w_cnt + 1'b1;
                            end
                        end else if (w_found) begin
                            r_head[w_cls]  <= w_head_nx;
                            r_count[w_cls] <= w_cnt - 1'b1;
                            r_pend_cls     <= w_cls;
                            r_state        <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_status     <= ST_SENT;
            r_sent_tag   <= w_rd64[31:0];
            r_sent_class <= 2'(r_pend_cls);
        end else if (w_accept) begin
            r_sent_tag   <= '0;
            r_sent_class <= '0;
            if (i_action == ACT_PUSH) begin
                r_status <= w_full ? ST_FULL : ST_PUSHED;
            end else begin
                r_status <= ST_EMPTY;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_sent_tag   = r_sent_tag;
    assign o_sent_class = r_sent_class;

    `ASSERT_CLK(a_read_done, i_clk, i_rst_n, (r_state == S_READ) |=> (o_valid && (o_status == ST_SENT)), "send read did not deliver a sent beat")
    `ASSERT_NEVER(a_cnt_bound, i_clk, i_rst_n, w_cnt_ovf, "class count above slot count")
    `ASSERT_CLK(a_zero_fields, i_clk, i_rst_n, (o_valid && (o_status != ST_SENT)) |-> ((o_sent_tag == '0) && (o_sent_class == '0)), "non-send beat carries tag or class")
    `ASSERT_NEVER(a_read_collide, i_clk, i_rst_n, (r_state == S_READ) && r_out_valid, "result register busy during send read")

endmodule

`default_nettype wire
